// File: sv/ecal_pkg.sv
// Package with shared constants, types and calendar helper functions.
package ecal_pkg;

  localparam int unsigned SecsW = 31;
  localparam int unsigned DaysW = 15;

  localparam logic [SecsW-1:0] SecsPerDay  = 31'd86400;
  localparam logic [SecsW-1:0] SecsPerHour = 31'd3600;
  localparam logic [SecsW-1:0] SecsPerMin  = 31'd60;
  localparam logic [SecsW-1:0] DaysPerWeek = 31'd7;
  localparam logic [SecsW-1:0] LeapYearLen = 31'd366;
  localparam logic [SecsW-1:0] YearLen     = 31'd365;

  localparam logic [3:0] DayShiftTop  = 4'd14;
  localparam logic [3:0] HourShiftTop = 4'd4;
  localparam logic [3:0] MinShiftTop  = 4'd5;
  localparam logic [3:0] WdayShiftTop = 4'd11;

  localparam logic [7:0] FirstYear   = 8'd70;
  localparam logic [2:0] EpochWday   = 3'd4;
  localparam logic [3:0] MonFeb      = 4'd1;
  localparam logic [3:0] MonDec      = 4'd11;

  typedef enum logic [2:0] {
    StIdle,
    StDay,
    StHour,
    StMin,
    StWday,
    StYear,
    StMon,
    StDone
  } state_e;

  // Gregorian leap rule for years 1900..2155 given as years since 1900.
  function automatic logic is_leap(input logic [7:0] yr);
    is_leap = (yr[1:0] == 2'd0) && (yr != 8'd0) && (yr != 8'd200);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    month_len = len;
  endfunction

endpackage

// File: sv/ecal_if.sv
// Handshake interfaces for the timestamp input and the calendar result.
interface ecal_in_if;
  logic                       valid;
  logic                       ready;
  logic [ecal_pkg::SecsW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] second_of_minute;
  logic [5:0] minute_of_hour;
  logic [4:0] hour_of_day;
  logic [2:0] weekday;
  logic [7:0] year_since_1900;
  logic [8:0] day_of_year;
  logic [3:0] month_index;
  logic [4:0] day_of_month;

  modport source (
    output valid, output second_of_minute, output minute_of_hour, output hour_of_day,
    output weekday, output year_since_1900, output day_of_year, output month_index,
    output day_of_month, input ready
  );
  modport sink (
    input valid, input second_of_minute, input minute_of_hour, input hour_of_day,
    input weekday, input year_since_1900, input day_of_year, input month_index,
    input day_of_month, output ready
  );
endinterface

// File: sv/epoch_seconds_to_utc_calendar.sv
// Top level: converts seconds since the epoch into UTC calendar fields.
// One timestamp is converted at a time by a single shared compare-and-subtract
// unit under a small sequencer. A conversion loads the timestamp, splits off
// whole days, then the hour, the minute and the weekday, searches the year
// one elapsed year per step and the month one elapsed month per step, then
// holds the result until its transfer completes. The input is not ready
// from the transfer of a timestamp until the transfer of its result.
module epoch_seconds_to_utc_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  ecal_in_if.sink     in_i,
  ecal_out_if.source  out_o
);
  import ecal_pkg::*;

  state_e           state_q, state_d;
  logic [SecsW-1:0] acc_q, acc_d;
  logic [DaysW-1:0] quo_q, quo_d;
  logic [DaysW-1:0] days_q, days_d;
  logic [3:0]       k_q, k_d;
  logic [5:0]       sec_q, sec_d;
  logic [5:0]       min_q, min_d;
  logic [4:0]       hour_q, hour_d;
  logic [2:0]       wday_q, wday_d;
  logic [7:0]       year_q, year_d;
  logic [8:0]       yday_q, yday_d;
  logic [3:0]       mon_q, mon_d;
  logic [4:0]       dom_q, dom_d;
  logic             leap_q, leap_d;

  logic [SecsW-1:0] operand;
  logic [SecsW:0]   diff;
  logic             ge;
  logic [SecsW-1:0] acc_sub;
  logic [DaysW-1:0] quo_next;
  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;

  always_comb begin
    case (state_q)
      StDay:   operand = SecsPerDay << k_q;
      StHour:  operand = SecsPerHour << k_q;
      StMin:   operand = SecsPerMin << k_q;
      StWday:  operand = DaysPerWeek << k_q;
      StYear:  operand = is_leap(year_q) ? LeapYearLen : YearLen;
      StMon:   operand = {{(SecsW-5){1'b0}}, month_len(mon_q, leap_q)};
      default: operand = '0;
    endcase
  end

  assign diff     = {1'b0, acc_q} - {1'b0, operand};
  assign ge       = !diff[SecsW];
  assign acc_sub  = ge ? diff[SecsW-1:0] : acc_q;
  assign quo_next = {quo_q[DaysW-2:0], ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_xfer) state_d = StDay;
      StDay:   if (k_q == '0) state_d = StHour;
      StHour:  if (k_q == '0) state_d = StMin;
      StMin:   if (k_q == '0) state_d = StWday;
      StWday:  if (k_q == '0) state_d = StYear;
      StYear:  if (!ge) state_d = StMon;
      StMon:   if (!ge || mon_q == MonDec) state_d = StDone;
      StDone:  if (out_xfer) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    acc_d  = acc_q;
    quo_d  = quo_q;
    days_d = days_q;
    k_d    = k_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    wday_d = wday_q;
    year_d = year_q;
    yday_d = yday_q;
    mon_d  = mon_q;
    dom_d  = dom_q;
    leap_d = leap_q;
    case (state_q)
      StIdle: begin
        acc_d = in_i.epoch_seconds;
        quo_d = '0;
        k_d   = DayShiftTop;
      end
      StDay: begin
        acc_d = acc_sub;
        quo_d = quo_next;
        k_d   = k_q - 4'd1;
        if (k_q == '0) begin
          days_d = quo_next;
          k_d    = HourShiftTop;
        end
      end
      StHour: begin
        acc_d = acc_sub;
        quo_d = quo_next;
        k_d   = k_q - 4'd1;
        if (k_q == '0) begin
          hour_d = quo_next[4:0];
          k_d    = MinShiftTop;
        end
      end
      StMin: begin
        acc_d = acc_sub;
        quo_d = quo_next;
        k_d   = k_q - 4'd1;
        if (k_q == '0) begin
          min_d = quo_next[5:0];
          sec_d = acc_sub[5:0];
          acc_d = {{(SecsW-DaysW-1){1'b0}}, {1'b0, days_q} + {{DaysW-2{1'b0}}, EpochWday}};
          k_d   = WdayShiftTop;
        end
      end
      StWday: begin
        acc_d = acc_sub;
        k_d   = k_q - 4'd1;
        if (k_q == '0) begin
          wday_d = acc_sub[2:0];
          acc_d  = {{(SecsW-DaysW){1'b0}}, days_q};
          year_d = FirstYear;
        end
      end
      StYear: begin
        acc_d = acc_sub;
        if (ge) begin
          year_d = year_q + 8'd1;
        end else begin
          yday_d = acc_q[8:0];
          leap_d = is_leap(year_q);
          mon_d  = '0;
        end
      end
      StMon: begin
        if (ge && mon_q != MonDec) begin
          acc_d = acc_sub;
          mon_d = mon_q + 4'd1;
        end else begin
          dom_d = acc_q[4:0] + 5'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    quo_q  <= quo_d;
    days_q <= days_d;
    k_q    <= k_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hour_q <= hour_d;
    wday_q <= wday_d;
    year_q <= year_d;
    yday_q <= yday_d;
    mon_q  <= mon_d;
    dom_q  <= dom_d;
    leap_q <= leap_d;
  end

  assign in_i.ready             = (state_q == StIdle);
  assign out_o.valid            = (state_q == StDone);
  assign out_o.second_of_minute = sec_q;
  assign out_o.minute_of_hour   = min_q;
  assign out_o.hour_of_day      = hour_q;
  assign out_o.weekday          = wday_q;
  assign out_o.year_since_1900  = year_q;
  assign out_o.day_of_year      = yday_q;
  assign out_o.month_index      = mon_q;
  assign out_o.day_of_month     = dom_q;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("Input is ready while a result is pending.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (!out_o.valid && !in_i.ready))
    else $error("Block did not start a conversion after an input transfer.");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMon) |-> (mon_q <= MonDec))
    else $error("Month search ran past December.");

  a_result_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.day_of_month != 5'd0 && out_o.weekday != 3'd7
                     && out_o.hour_of_day < 5'd24))
    else $error("Result holds an impossible calendar field.");
`endif

endmodule
